/* rtl/cbor_enc_pkg.sv */
`default_nettype none

package cbor_enc_pkg;

  // Request codes
  localparam logic [3:0] FuncUint    = 4'd0;
  localparam logic [3:0] FuncBstr    = 4'd1;
  localparam logic [3:0] FuncTstr    = 4'd2;
  localparam logic [3:0] FuncArray   = 4'd3;
  localparam logic [3:0] FuncMap     = 4'd4;
  localparam logic [3:0] FuncFalse   = 4'd5;
  localparam logic [3:0] FuncTrue    = 4'd6;
  localparam logic [3:0] FuncNull    = 4'd7;
  localparam logic [3:0] FuncF32     = 4'd8;
  localparam logic [3:0] FuncF64     = 4'd9;
  localparam logic [3:0] FuncPayload = 4'd10;

  // Major types
  localparam logic [2:0] MajorUint  = 3'd0;
  localparam logic [2:0] MajorBstr  = 3'd2;
  localparam logic [2:0] MajorTstr  = 3'd3;
  localparam logic [2:0] MajorArray = 3'd4;
  localparam logic [2:0] MajorMap   = 3'd5;

  // Additional info codes for following-argument forms
  localparam logic [4:0] AiInlineMax = 5'd23;
  localparam logic [4:0] Ai1Byte     = 5'd24;
  localparam logic [4:0] Ai2Byte     = 5'd25;
  localparam logic [4:0] Ai4Byte     = 5'd26;
  localparam logic [4:0] Ai8Byte     = 5'd27;

  // Single-byte initial bytes
  localparam logic [7:0] ByteFalse = 8'hF4;
  localparam logic [7:0] ByteTrue  = 8'hF5;
  localparam logic [7:0] ByteNull  = 8'hF6;
  localparam logic [7:0] ByteF32   = 8'hFA;
  localparam logic [7:0] ByteF64   = 8'hFB;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic [3:0]  func;
    logic [63:0] value;
  } cbor_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } cbor_out_t;

  // One classified request: initial byte, argument bytes and their count (0, 1, 2, 4 or 8)
  typedef struct packed {
    logic [7:0]  head;
    logic [63:0] data;
    logic [3:0]  nbytes;
  } cbor_entry_t;

endpackage

`default_nettype wire

/* rtl/cbor_enc_front.sv */
`default_nettype none

module cbor_enc_front import cbor_enc_pkg::*; (
  input  wire cbor_in_t    req_i,
  output logic             known_o,
  output cbor_entry_t      entry_o
);

  logic [2:0] major;
  logic       is_head;

  always_comb begin
    known_o = 1'b1;
    is_head = 1'b0;
    major   = MajorUint;
    entry_o.head   = 8'h00;
    entry_o.data   = req_i.value;
    entry_o.nbytes = 4'd0;
    case (req_i.func)
      FuncUint:    begin is_head = 1'b1; major = MajorUint;  end
      FuncBstr:    begin is_head = 1'b1; major = MajorBstr;  end
      FuncTstr:    begin is_head = 1'b1; major = MajorTstr;  end
      FuncArray:   begin is_head = 1'b1; major = MajorArray; end
      FuncMap:     begin is_head = 1'b1; major = MajorMap;   end
      FuncFalse:   entry_o.head = ByteFalse;
      FuncTrue:    entry_o.head = ByteTrue;
      FuncNull:    entry_o.head = ByteNull;
      FuncF32: begin
        entry_o.head   = ByteF32;
        entry_o.data   = {32'h0, req_i.value[31:0]};
        entry_o.nbytes = 4'd4;
      end
      FuncF64: begin
        entry_o.head   = ByteF64;
        entry_o.nbytes = 4'd8;
      end
      FuncPayload: entry_o.head = req_i.value[7:0];
      default:     known_o = 1'b0;
    endcase

    // shortest argument form
    if (is_head) begin
      if (req_i.value <= 64'(AiInlineMax)) begin
        entry_o.head = {major, req_i.value[4:0]};
      end else if (req_i.value[63:8] == '0) begin
        entry_o.head   = {major, Ai1Byte};
        entry_o.nbytes = 4'd1;
      end else if (req_i.value[63:16] == '0) begin
        entry_o.head   = {major, Ai2Byte};
        entry_o.nbytes = 4'd2;
      end else if (req_i.value[63:32] == '0) begin
        entry_o.head   = {major, Ai4Byte};
        entry_o.nbytes = 4'd4;
      end else begin
        entry_o.head   = {major, Ai8Byte};
        entry_o.nbytes = 4'd8;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cbor_enc_queue.sv */
`default_nettype none

module cbor_enc_queue import cbor_enc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire cbor_entry_t push_entry_i,
  output logic             full_o,
  output logic             valid_o,
  output cbor_entry_t      head_o,
  input  wire              pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cbor_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/cbor_enc_back.sv */
`default_nettype none

module cbor_enc_back import cbor_enc_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  input  wire cbor_entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output cbor_out_t        out_o
);

  logic [3:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  cbor_out_t  out_q, out_d;
  logic       advance, is_last;
  logic [2:0] sel;
  logic [7:0] data_byte;

  assign advance  = !out_valid_q || out_ready_i;
  assign is_last  = (idx_q == entry_i.nbytes);
  // byte index k of n argument bytes sits at byte position n-k of the data
  assign sel      = entry_i.nbytes[2:0] - idx_q[2:0];
  assign data_byte = entry_i.data[{sel, 3'b000} +: 8];
  assign pop_o    = advance && valid_i && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = valid_i;
      if (valid_i) begin
        out_d.out_byte = (idx_q == '0) ? entry_i.head : data_byte;
        out_d.last     = is_last;
        idx_d          = is_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

/* rtl/cbor_item_head_encoder.sv */
`default_nettype none

// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+------------------------------
// request  | in  | in_valid_i / in_ready_o   | in_i  (func, value)
// bytes    | out | out_valid_o / out_ready_i | out_o (out_byte, last)
//
// Each known request yields 1 to 9 byte transactions; the serializer emits one byte
// per cycle while out_ready_i is high, and single-byte requests then flow at one per
// cycle. Unused func codes are accepted and produce no bytes.
// The request queue (QueueDepth entries) decouples the input from the serializer.
// Reset clears queue pointers and the output valid; no clearing pass is needed.
// A stalled output holds its byte and back-pressures the queue, then the input.
module cbor_item_head_encoder import cbor_enc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault  // 2..16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  wire cbor_in_t in_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output cbor_out_t     out_o
);

  logic        known;
  cbor_entry_t front_entry;
  logic        q_full, q_valid, q_pop;
  cbor_entry_t q_head;

  // Front: classify the request into initial byte plus argument bytes
  cbor_enc_front u_front (
    .req_i   (in_i),
    .known_o (known),
    .entry_o (front_entry)
  );

  assign in_ready_o = !q_full;

  cbor_enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i && known),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .head_o       (q_head),
    .pop_i        (q_pop)
  );

  // Back: serialize bytes, most significant argument byte first
  cbor_enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
